[rtl/sdsi_pkg.sv]
// Shared types, codes and helper functions for the SD card SPI-mode command engine.
`timescale 1ns / 1ps

package sdsi_pkg;

    localparam logic [1:0] OP_START_CMD  = 2'd0;
    localparam logic [1:0] OP_START_INIT = 2'd1;
    localparam logic [1:0] OP_EXCHANGE   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TIMEOUT   = 2'd1;
    localparam logic [1:0] ST_INIT_FAIL = 2'd2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_R1   = 2'd1;
    localparam logic [1:0] KIND_R7   = 2'd2;

    localparam logic [1:0] CFG_POLL_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] CFG_DUMMY_COUNT = 2'd2;

    localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
    localparam logic [5:0] CMD_VOLT_CHECK   = 6'd8;
    localparam logic [5:0] CMD_APP          = 6'd55;
    localparam logic [5:0] ACMD_OP_COND     = 6'd41;

    localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
    localparam logic [31:0] ARG_OP_COND = 32'h4000_0000;
    localparam logic [31:0] ARG_NONE    = 32'h0000_0000;

    localparam logic [7:0] CMD_START_BITS = 8'h40;
    localparam logic [7:0] CRC_GO_IDLE    = 8'h95;
    localparam logic [7:0] CRC_OTHER      = 8'h87;
    localparam logic [7:0] FILL_BYTE      = 8'hFF;
    localparam logic [7:0] FRAME_LAST     = 8'd6;
    localparam logic [7:0] R7_TAIL_BYTES  = 8'd4;

    localparam logic [7:0] POLL_LIMIT_RST  = 8'd10;
    localparam logic [7:0] RETRY_LIMIT_RST = 8'd50;
    localparam logic [7:0] DUMMY_COUNT_RST = 8'd10;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_DUMMY = 5'b00010,
        PH_FRAME = 5'b00100,
        PH_POLL  = 5'b01000,
        PH_R7    = 5'b10000
    } phase_t;

    typedef enum logic [4:0] {
        INIT_OFF    = 5'b00001,
        INIT_CMD0   = 5'b00010,
        INIT_CMD8   = 5'b00100,
        INIT_CMD55  = 5'b01000,
        INIT_ACMD41 = 5'b10000
    } init_step_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  command_index;
        logic [31:0] argument;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic        tx_request;
        logic [7:0]  tx_byte;
        logic        card_selected;
        logic        done_res;
        logic [1:0]  status;
        logic [1:0]  response_kind;
        logic [7:0]  r1_byte;
        logic [31:0] r7_tail;
    } out_item_t;

    typedef struct packed {
        logic [7:0] poll_limit;
        logic [7:0] init_retry_limit;
        logic [7:0] dummy_byte_count;
    } cfg_t;

    // Commands whose response is kept as an R1 byte.
    function automatic logic captures_r1(input logic [5:0] idx);
        logic hit;
        case (idx) inside
            6'd0, 6'd1, 6'd6, 6'd9, 6'd10, 6'd16, 6'd17, 6'd18, 6'd24, 6'd25,
            6'd27, 6'd30, 6'd32, 6'd33, 6'd41, 6'd42, 6'd55, 6'd56, 6'd59: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic [7:0] frame_byte(input logic [7:0] k, input logic [5:0] cmd,
                                              input logic [31:0] arg);
        logic [7:0] b;
        case (k)
            8'd0:    b = CMD_START_BITS | {2'b00, cmd};
            8'd1:    b = arg[31:24];
            8'd2:    b = arg[23:16];
            8'd3:    b = arg[15:8];
            8'd4:    b = arg[7:0];
            default: b = (cmd == CMD_GO_IDLE) ? CRC_GO_IDLE : CRC_OTHER;
        endcase
        return b;
    endfunction

endpackage

[rtl/sd_spi_command_and_init_engine_top.sv]
// Top level of the SD card SPI-mode command and init engine.
//
//  Channel  Ports                         Direction  Moves
//  s_       s_valid s_ready s_data        in         one request (start or byte exchange)
//  m_       m_valid m_ready m_data        out        one result per request
//  cfg_     cfg_valid cfg_ready cfg_index cfg_data   in   configuration register write
//
// Each request's result is formed combinationally and registered in the output buffer.
// A new request is taken every cycle until the skid slot fills; it holds one result while the output stalls.
// Reset is synchronous on aresetn low and returns the sequencer to idle with default limits.
// Configuration writes are always taken; cfg_ready is tied high.
`timescale 1ns / 1ps

module sd_spi_command_and_init_engine_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sdsi_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sdsi_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    sdsi_pkg::cfg_t      cfg_reg;
    sdsi_pkg::out_item_t step_result;
    logic                accept;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.poll_limit       <= sdsi_pkg::POLL_LIMIT_RST;
            cfg_reg.init_retry_limit <= sdsi_pkg::RETRY_LIMIT_RST;
            cfg_reg.dummy_byte_count <= sdsi_pkg::DUMMY_COUNT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sdsi_pkg::CFG_POLL_LIMIT:  cfg_reg.poll_limit       <= cfg_data;
                sdsi_pkg::CFG_RETRY_LIMIT: cfg_reg.init_retry_limit <= cfg_data;
                sdsi_pkg::CFG_DUMMY_COUNT: cfg_reg.dummy_byte_count <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    sdsi_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_data),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    sdsi_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_ready  (s_ready),
        .in_data   (step_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

[rtl/sdsi_core.sv]
// Command and init sequencer: state registers and the per-request next-state and result logic.
`timescale 1ns / 1ps

module sdsi_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  sdsi_pkg::in_item_t item,
    input  sdsi_pkg::cfg_t    cfg,
    output sdsi_pkg::out_item_t result
);

    sdsi_pkg::phase_t     phase_reg, phase_next;
    sdsi_pkg::init_step_t step_reg, step_next;
    logic [7:0]  byte_cnt_reg, byte_cnt_next;
    logic [7:0]  poll_cnt_reg, poll_cnt_next;
    logic [7:0]  retry_cnt_reg, retry_cnt_next;
    logic [5:0]  cmd_reg, cmd_next;
    logic [31:0] arg_reg, arg_next;
    logic [7:0]  r1_reg, r1_next;
    logic [31:0] r7_reg, r7_next;
    logic [1:0]  kind_reg, kind_next;

    always_comb begin
        logic        do_begin;
        logic [5:0]  begin_idx;
        logic [31:0] begin_arg;
        logic        fin;
        logic [1:0]  fin_status;
        logic        poll_step;
        logic [7:0]  poll_base;
        logic        done;
        logic [1:0]  status;
        logic        loop_check;

        phase_next     = phase_reg;
        step_next      = step_reg;
        byte_cnt_next  = byte_cnt_reg;
        poll_cnt_next  = poll_cnt_reg;
        retry_cnt_next = retry_cnt_reg;
        cmd_next       = cmd_reg;
        arg_next       = arg_reg;
        r1_next        = r1_reg;
        r7_next        = r7_reg;
        kind_next      = kind_reg;
        do_begin       = 1'b0;
        begin_idx      = sdsi_pkg::CMD_GO_IDLE;
        begin_arg      = sdsi_pkg::ARG_NONE;
        fin            = 1'b0;
        fin_status     = sdsi_pkg::ST_OK;
        poll_step      = 1'b0;
        poll_base      = poll_cnt_reg;
        done           = 1'b0;
        status         = sdsi_pkg::ST_OK;
        loop_check     = 1'b0;

        if (item.operation == sdsi_pkg::OP_START_CMD && phase_reg == sdsi_pkg::PH_IDLE) begin
            step_next = sdsi_pkg::INIT_OFF;
            do_begin  = 1'b1;
            begin_idx = item.command_index;
            begin_arg = item.argument;
        end else if (item.operation == sdsi_pkg::OP_START_INIT &&
                     phase_reg == sdsi_pkg::PH_IDLE) begin
            step_next      = sdsi_pkg::INIT_CMD0;
            retry_cnt_next = 8'd0;
            byte_cnt_next  = 8'd0;
            if (cfg.dummy_byte_count == 8'd0) begin
                do_begin = 1'b1;
            end else begin
                phase_next = sdsi_pkg::PH_DUMMY;
            end
        end else if (item.operation == sdsi_pkg::OP_EXCHANGE) begin
            unique case (phase_reg)
                sdsi_pkg::PH_DUMMY: begin
                    byte_cnt_next = byte_cnt_reg + 8'd1;
                    if (byte_cnt_next == cfg.dummy_byte_count) begin
                        do_begin = 1'b1;
                    end
                end
                sdsi_pkg::PH_FRAME: begin
                    byte_cnt_next = byte_cnt_reg + 8'd1;
                    if (byte_cnt_next >= sdsi_pkg::FRAME_LAST) begin
                        poll_step = 1'b1;
                        poll_base = 8'd0;
                    end
                end
                sdsi_pkg::PH_POLL: begin
                    if (!item.rx_byte[7]) begin
                        if (cmd_reg == sdsi_pkg::CMD_VOLT_CHECK) begin
                            r1_next       = item.rx_byte;
                            byte_cnt_next = 8'd0;
                            phase_next    = sdsi_pkg::PH_R7;
                        end else begin
                            if (sdsi_pkg::captures_r1(cmd_reg)) begin
                                r1_next   = item.rx_byte;
                                kind_next = sdsi_pkg::KIND_R1;
                            end else begin
                                kind_next = sdsi_pkg::KIND_NONE;
                            end
                            fin = 1'b1;
                        end
                    end else begin
                        poll_step = 1'b1;
                    end
                end
                sdsi_pkg::PH_R7: begin
                    r7_next       = {r7_reg[23:0], item.rx_byte};
                    byte_cnt_next = byte_cnt_reg + 8'd1;
                    if (byte_cnt_next >= sdsi_pkg::R7_TAIL_BYTES) begin
                        kind_next = sdsi_pkg::KIND_R7;
                        fin       = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (poll_step) begin
            poll_cnt_next = poll_base + 8'd1;
            if (poll_cnt_next == cfg.poll_limit) begin
                kind_next  = sdsi_pkg::KIND_NONE;
                fin        = 1'b1;
                fin_status = sdsi_pkg::ST_TIMEOUT;
            end else begin
                phase_next = sdsi_pkg::PH_POLL;
            end
        end

        if (fin) begin
            phase_next = sdsi_pkg::PH_IDLE;
            unique case (step_reg)
                sdsi_pkg::INIT_OFF: begin
                    done   = 1'b1;
                    status = fin_status;
                end
                sdsi_pkg::INIT_CMD0: begin
                    do_begin  = 1'b1;
                    begin_idx = sdsi_pkg::CMD_VOLT_CHECK;
                    begin_arg = sdsi_pkg::ARG_IF_COND;
                    step_next = sdsi_pkg::INIT_CMD8;
                end
                sdsi_pkg::INIT_CMD8: begin
                    retry_cnt_next = 8'd0;
                    loop_check     = 1'b1;
                end
                sdsi_pkg::INIT_CMD55: begin
                    do_begin  = 1'b1;
                    begin_idx = sdsi_pkg::ACMD_OP_COND;
                    begin_arg = sdsi_pkg::ARG_OP_COND;
                    step_next = sdsi_pkg::INIT_ACMD41;
                end
                sdsi_pkg::INIT_ACMD41: begin
                    retry_cnt_next = retry_cnt_reg + 8'd1;
                    loop_check     = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (loop_check) begin
            if (r1_next[0] && retry_cnt_next != cfg.init_retry_limit) begin
                do_begin  = 1'b1;
                begin_idx = sdsi_pkg::CMD_APP;
                begin_arg = sdsi_pkg::ARG_NONE;
                step_next = sdsi_pkg::INIT_CMD55;
            end else begin
                step_next = sdsi_pkg::INIT_OFF;
                done      = 1'b1;
                status    = r1_next[0] ? sdsi_pkg::ST_INIT_FAIL : sdsi_pkg::ST_OK;
            end
        end

        if (do_begin) begin
            cmd_next      = begin_idx;
            arg_next      = begin_arg;
            byte_cnt_next = 8'd0;
            r1_next       = 8'hFF;
            r7_next       = 32'hFFFF_FFFF;
            kind_next     = sdsi_pkg::KIND_NONE;
            phase_next    = sdsi_pkg::PH_FRAME;
        end

        result.tx_request    = 1'b0;
        result.tx_byte       = 8'h00;
        result.card_selected = 1'b0;
        unique case (phase_next)
            sdsi_pkg::PH_DUMMY: begin
                result.tx_request = 1'b1;
                result.tx_byte    = sdsi_pkg::FILL_BYTE;
            end
            sdsi_pkg::PH_FRAME: begin
                result.tx_request    = 1'b1;
                result.tx_byte       = sdsi_pkg::frame_byte(byte_cnt_next, cmd_next, arg_next);
                result.card_selected = 1'b1;
            end
            sdsi_pkg::PH_POLL, sdsi_pkg::PH_R7: begin
                result.tx_request    = 1'b1;
                result.tx_byte       = sdsi_pkg::FILL_BYTE;
                result.card_selected = 1'b1;
            end
            default: begin
            end
        endcase
        result.done_res      = done;
        result.status        = done ? status : sdsi_pkg::ST_OK;
        result.response_kind = done ? kind_next : sdsi_pkg::KIND_NONE;
        result.r1_byte       = r1_next;
        result.r7_tail       = r7_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= sdsi_pkg::PH_IDLE;
            step_reg      <= sdsi_pkg::INIT_OFF;
            byte_cnt_reg  <= 8'd0;
            poll_cnt_reg  <= 8'd0;
            retry_cnt_reg <= 8'd0;
            cmd_reg       <= 6'd0;
            arg_reg       <= 32'd0;
            r1_reg        <= 8'hFF;
            r7_reg        <= 32'hFFFF_FFFF;
            kind_reg      <= sdsi_pkg::KIND_NONE;
        end else if (accept) begin
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            byte_cnt_reg  <= byte_cnt_next;
            poll_cnt_reg  <= poll_cnt_next;
            retry_cnt_reg <= retry_cnt_next;
            cmd_reg       <= cmd_next;
            arg_reg       <= arg_next;
            r1_reg        <= r1_next;
            r7_reg        <= r7_next;
            kind_reg      <= kind_next;
        end
    end

endmodule

[rtl/sdsi_out_buf.sv]
// Two-entry result register with skid slot, so a new request is taken while a result waits.
`timescale 1ns / 1ps

module sdsi_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sdsi_pkg::out_item_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sdsi_pkg::out_item_t out_data
);

    logic                main_valid_reg;
    logic                skid_valid_reg;
    sdsi_pkg::out_item_t main_reg;
    sdsi_pkg::out_item_t skid_reg;
    logic                take;

    assign take      = main_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_valid) begin
            if (main_valid_reg && !take) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end else if (take) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                main_reg <= skid_reg;
            end
        end else if (in_valid) begin
            if (main_valid_reg && !take) begin
                skid_reg <= in_data;
            end else begin
                main_reg <= in_data;
            end
        end
    end

endmodule

[verif/sdsi_result_checker.sv]
// Checker for the SD SPI command engine: predicts every result and compares it with the output.
`timescale 1ns / 1ps

module sdsi_result_checker import sdsi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          pending
);

    // Bit n is set when command n keeps its response as an R1 byte.
    localparam logic [63:0] R1_CMDS = 64'h0980_0603_4B07_0643;

    logic [7:0]  lim_poll;
    logic [7:0]  lim_retry;
    logic [7:0]  n_dummy;
    phase_t      eng_phase;
    init_step_t  init_stage;
    logic [7:0]  byte_cnt;
    logic [7:0]  poll_cnt;
    logic [7:0]  round_cnt;
    logic [5:0]  cur_cmd;
    logic [31:0] cur_arg;
    logic [7:0]  r1_hold;
    logic [31:0] r7_hold;
    logic [1:0]  kind_last;
    out_item_t   step_out_q[$];
    out_item_t   want;

    function automatic void launch_cmd(input logic [5:0] idx, input logic [31:0] arg);
        cur_cmd = idx;
        cur_arg = arg;
        byte_cnt = '0;
        r1_hold = FILL_BYTE;
        r7_hold = '1;
        kind_last = KIND_NONE;
        eng_phase = PH_FRAME;
    endfunction

    function automatic bit another_round();
        if (r1_hold[0] && round_cnt != lim_retry) begin
            launch_cmd(CMD_APP, ARG_NONE);
            init_stage = INIT_CMD55;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit close_cmd(input logic [1:0] st_in, output logic [1:0] st_out);
        bit ended;
        eng_phase = PH_IDLE;
        st_out = ST_OK;
        ended = 1'b0;
        case (init_stage)
            INIT_OFF: begin
                st_out = st_in;
                return 1'b1;
            end
            INIT_CMD0: begin
                launch_cmd(CMD_VOLT_CHECK, ARG_IF_COND);
                init_stage = INIT_CMD8;
                return 1'b0;
            end
            INIT_CMD8: begin
                round_cnt = '0;
                ended = !another_round();
            end
            INIT_CMD55: begin
                launch_cmd(ACMD_OP_COND, ARG_OP_COND);
                init_stage = INIT_ACMD41;
                return 1'b0;
            end
            default: begin
                round_cnt = round_cnt + 8'd1;
                ended = !another_round();
            end
        endcase
        if (!ended)
            return 1'b0;
        init_stage = INIT_OFF;
        eng_phase = PH_IDLE;
        st_out = r1_hold[0] ? ST_INIT_FAIL : ST_OK;
        return 1'b1;
    endfunction

    function automatic bit poll_once(output logic [1:0] st_out);
        st_out = ST_OK;
        poll_cnt = poll_cnt + 8'd1;
        if (poll_cnt == lim_poll) begin
            kind_last = KIND_NONE;
            return close_cmd(ST_TIMEOUT, st_out);
        end
        eng_phase = PH_POLL;
        return 1'b0;
    endfunction

    function automatic out_item_t engine_step(input in_item_t rq);
        out_item_t   res;
        logic [1:0]  st;
        logic [31:0] shifted;
        bit          fin;
        st = ST_OK;
        fin = 1'b0;
        if (rq.operation == OP_START_CMD && eng_phase == PH_IDLE) begin
            init_stage = INIT_OFF;
            launch_cmd(rq.command_index, rq.argument);
        end else if (rq.operation == OP_START_INIT && eng_phase == PH_IDLE) begin
            init_stage = INIT_CMD0;
            round_cnt = '0;
            byte_cnt = '0;
            if (n_dummy == 8'd0)
                launch_cmd(CMD_GO_IDLE, ARG_NONE);
            else
                eng_phase = PH_DUMMY;
        end else if (rq.operation == OP_EXCHANGE) begin
            case (eng_phase)
                PH_DUMMY: begin
                    byte_cnt = byte_cnt + 8'd1;
                    if (byte_cnt == n_dummy)
                        launch_cmd(CMD_GO_IDLE, ARG_NONE);
                end
                PH_FRAME: begin
                    byte_cnt = byte_cnt + 8'd1;
                    if (byte_cnt >= FRAME_LAST) begin
                        poll_cnt = '0;
                        fin = poll_once(st);
                    end
                end
                PH_POLL: begin
                    if (!rq.rx_byte[7]) begin
                        if (cur_cmd == CMD_VOLT_CHECK) begin
                            r1_hold = rq.rx_byte;
                            byte_cnt = '0;
                            eng_phase = PH_R7;
                        end else begin
                            if (R1_CMDS[cur_cmd]) begin
                                r1_hold = rq.rx_byte;
                                kind_last = KIND_R1;
                            end else begin
                                kind_last = KIND_NONE;
                            end
                            fin = close_cmd(ST_OK, st);
                        end
                    end else begin
                        fin = poll_once(st);
                    end
                end
                PH_R7: begin
                    r7_hold = {r7_hold[23:0], rq.rx_byte};
                    byte_cnt = byte_cnt + 8'd1;
                    if (byte_cnt >= R7_TAIL_BYTES) begin
                        kind_last = KIND_R7;
                        fin = close_cmd(ST_OK, st);
                    end
                end
                default: ;
            endcase
        end

        res = '0;
        case (eng_phase)
            PH_DUMMY: begin
                res.tx_request = 1'b1;
                res.tx_byte = FILL_BYTE;
            end
            PH_FRAME: begin
                res.tx_request = 1'b1;
                res.card_selected = 1'b1;
                if (byte_cnt == 8'd0) begin
                    res.tx_byte = CMD_START_BITS | {2'b00, cur_cmd};
                end else if (byte_cnt <= 8'd4) begin
                    shifted = cur_arg >> (8 * (4 - byte_cnt));
                    res.tx_byte = shifted[7:0];
                end else begin
                    res.tx_byte = (cur_cmd == CMD_GO_IDLE) ? CRC_GO_IDLE : CRC_OTHER;
                end
            end
            PH_POLL, PH_R7: begin
                res.tx_request = 1'b1;
                res.tx_byte = FILL_BYTE;
                res.card_selected = 1'b1;
            end
            default: ;
        endcase
        res.done_res = fin;
        res.status = fin ? st : ST_OK;
        res.response_kind = fin ? kind_last : KIND_NONE;
        res.r1_byte = r1_hold;
        res.r7_tail = r7_hold;
        return res;
    endfunction

    function automatic void check_field(input string fname, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, fname, exp_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            lim_poll = POLL_LIMIT_RST;
            lim_retry = RETRY_LIMIT_RST;
            n_dummy = DUMMY_COUNT_RST;
            eng_phase = PH_IDLE;
            init_stage = INIT_OFF;
            byte_cnt = '0;
            poll_cnt = '0;
            round_cnt = '0;
            cur_cmd = '0;
            cur_arg = '0;
            r1_hold = FILL_BYTE;
            r7_hold = '1;
            kind_last = KIND_NONE;
            step_out_q.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_POLL_LIMIT:  lim_poll = cfg_data;
                    CFG_RETRY_LIMIT: lim_retry = cfg_data;
                    CFG_DUMMY_COUNT: n_dummy = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (step_out_q.size() == 0) begin
                    $display("%0t: result with no request waiting, expected none, got %h",
                             $time, m_data);
                    fail_count++;
                end else begin
                    want = step_out_q.pop_front();
                    check_field("tx_request", 32'(want.tx_request), 32'(m_data.tx_request));
                    check_field("tx_byte", 32'(want.tx_byte), 32'(m_data.tx_byte));
                    check_field("card_selected", 32'(want.card_selected),
                                32'(m_data.card_selected));
                    check_field("done_res", 32'(want.done_res), 32'(m_data.done_res));
                    check_field("status", 32'(want.status), 32'(m_data.status));
                    check_field("response_kind", 32'(want.response_kind),
                                32'(m_data.response_kind));
                    check_field("r1_byte", 32'(want.r1_byte), 32'(m_data.r1_byte));
                    check_field("r7_tail", want.r7_tail, m_data.r7_tail);
                end
            end
            if (s_valid && s_ready)
                step_out_q.push_back(engine_step(s_data));
            pending = step_out_q.size();
        end
    end

endmodule

[verif/sd_spi_command_and_init_engine_top_tb.sv]
// Testbench top for the SD SPI command engine: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module sd_spi_command_and_init_engine_top_tb;
    import sdsi_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         RAND_ITEMS  = 1300;
    localparam int         NUM_PHASES  = 6;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_POLL_LIMIT;
    logic [7:0]  cfg_data = '0;
    int          fail_count;
    int          pending;
    int          sent = 0;
    int          finished_seqs = 0;
    int          settings = 1;
    int          cycle_count = 0;
    bit          no_idle = 1'b0;

    sd_spi_command_and_init_engine_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sdsi_result_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #10 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 31);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready && m_data.done_res)
            finished_seqs <= finished_seqs + 1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[sd_spi_command_and_init_engine_top] ERROR");
            $finish;
        end
    end

    function automatic in_item_t req_item(input logic [1:0] op, input logic [5:0] idx,
                                          input logic [31:0] arg, input logic [7:0] rx);
        in_item_t r;
        r.operation = op;
        r.command_index = idx;
        r.argument = arg;
        r.rx_byte = rx;
        return r;
    endfunction

    // Starts and returns at a falling edge; the request stays up until taken.
    task automatic issue(input in_item_t rq);
        if (!no_idle) begin
            while ($urandom_range(99) < 31) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data <= rq;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent++;
        @(negedge aclk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_limits(input logic [7:0] poll, input logic [7:0] retry,
                                input logic [7:0] dummy);
        put_reg(CFG_POLL_LIMIT, poll);
        put_reg(CFG_RETRY_LIMIT, retry);
        put_reg(CFG_DUMMY_COUNT, dummy);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic run_episode();
        int          resp_pct;
        int          d0;
        int          n;
        bit          is_init;
        logic [5:0]  idx;
        logic [31:0] arg;
        logic [7:0]  rx;
        in_item_t    rq;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 3))
                issue(req_item($urandom_range(1) ? OP_EXCHANGE : OP_UNUSED,
                               6'($urandom), $urandom, 8'($urandom)));
        end
        is_init = ($urandom_range(3) == 0);
        case ($urandom_range(2))
            0: resp_pct = 5;
            1: resp_pct = 30;
            default: resp_pct = 70;
        endcase
        case ($urandom_range(7))
            0: idx = CMD_GO_IDLE;
            1: idx = CMD_VOLT_CHECK;
            2: idx = CMD_APP;
            3: idx = ACMD_OP_COND;
            default: idx = 6'($urandom);
        endcase
        case ($urandom_range(5))
            0: arg = '0;
            1: arg = '1;
            default: arg = $urandom;
        endcase
        d0 = finished_seqs;
        issue(req_item(is_init ? OP_START_INIT : OP_START_CMD, idx, arg, 8'($urandom)));
        n = 0;
        while (finished_seqs == d0) begin
            rx = 8'($urandom);
            rx[7] = ($urandom_range(99) >= resp_pct);
            if (is_init)
                rx[0] = ($urandom_range(99) < 50);
            if (n == 0 && $urandom_range(4) == 0)
                rq = req_item($urandom_range(1) ? OP_START_CMD : OP_START_INIT,
                              6'($urandom), $urandom, rx);
            else if ($urandom_range(49) == 0)
                rq = req_item(OP_UNUSED, 6'($urandom), $urandom, rx);
            else
                rq = req_item(OP_EXCHANGE, 6'($urandom), $urandom, rx);
            issue(rq);
            n++;
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        issue(req_item(OP_EXCHANGE, '0, '0, 8'hFF));
        issue(req_item(OP_UNUSED, 6'h3F, '1, 8'h00));
        issue(req_item(OP_START_CMD, CMD_VOLT_CHECK, '1, 8'h00));
        repeat (6) issue(req_item(OP_EXCHANGE, 6'h3F, '1, 8'h00));
        issue(req_item(OP_EXCHANGE, '0, '0, 8'h80));
        issue(req_item(OP_START_INIT, '0, '0, 8'hFF));
        issue(req_item(OP_EXCHANGE, '0, '0, 8'h01));
        issue(req_item(OP_EXCHANGE, '0, '0, 8'h00));
        issue(req_item(OP_EXCHANGE, '0, '0, 8'h00));
        issue(req_item(OP_EXCHANGE, '0, '0, 8'h01));
        issue(req_item(OP_EXCHANGE, '0, '0, 8'hAA));
        issue(req_item(OP_START_CMD, 6'h3F, '0, 8'h00));
        repeat (6) issue(req_item(OP_EXCHANGE, '0, '0, 8'hFF));
        issue(req_item(OP_EXCHANGE, '0, '0, 8'h7F));

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                // Every request must have its result back before the limits change.
                s_valid <= 1'b0;
                while (pending != 0)
                    @(negedge aclk);
                case (p)
                    1: write_limits(8'd2, 8'd1, 8'd1);
                    2: write_limits(8'd255, 8'd255, 8'd255);
                    3: write_limits(POLL_LIMIT_RST, RETRY_LIMIT_RST, DUMMY_COUNT_RST);
                    default: write_limits(8'($urandom_range(2, 255)), 8'($urandom_range(1, 8)),
                                          8'($urandom_range(1, 20)));
                endcase
            end
            no_idle = (p == 3);
            while (sent < 24 + RAND_ITEMS * (p + 1) / NUM_PHASES)
                run_episode();
        end

        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("Run covered %0d requests under %0d limit settings.", sent, settings);
        $display("Commands and init sequences finished: %0d.", finished_seqs);
        if (fail_count == 0)
            $display("[sd_spi_command_and_init_engine_top] OK");
        else
            $display("[sd_spi_command_and_init_engine_top] ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/sdsi_pkg.sv
rtl/sdsi_core.sv
rtl/sdsi_out_buf.sv
rtl/sd_spi_command_and_init_engine_top.sv
verif/sdsi_result_checker.sv
verif/sd_spi_command_and_init_engine_top_tb.sv
